FILE: src/utf8_seg_pkg.sv
// ----------------------------------------------------------------------------
// utf8_seg_pkg
// Shared types, byte constants and helpers for the UTF-8 character segmenter.
// ----------------------------------------------------------------------------
package utf8_seg_pkg;

  // Width of the internal running character counter
  localparam int COUNT_WIDTH = 32;
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  // Lead byte ranges
  localparam logic [7:0] LEAD_MIN   = 8'hC2;
  localparam logic [7:0] LEAD_MAX   = 8'hF4;
  localparam logic [7:0] LEAD_3_MIN = 8'hE0;
  localparam logic [7:0] LEAD_4_MIN = 8'hF0;

  // Leads with tightened first-continuation bounds
  localparam logic [7:0] LEAD_E0 = 8'hE0;
  localparam logic [7:0] LEAD_ED = 8'hED;
  localparam logic [7:0] LEAD_F0 = 8'hF0;
  localparam logic [7:0] LEAD_F4 = 8'hF4;

  // Continuation bounds
  localparam logic [7:0] CONT_MIN    = 8'h80;
  localparam logic [7:0] CONT_MAX    = 8'hBF;
  localparam logic [7:0] E0_CONT_MIN = 8'hA0;
  localparam logic [7:0] ED_CONT_MAX = 8'h9F;
  localparam logic [7:0] F0_CONT_MIN = 8'h90;
  localparam logic [7:0] F4_CONT_MAX = 8'h8F;

  // Literal U+FFFD encoding: EF BF BD
  localparam logic [7:0] REPL_LEAD = 8'hEF;
  localparam logic [7:0] REPL_MID  = 8'hBF;
  localparam logic [7:0] REPL_LAST = 8'hBD;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_text;
  } byte_item_t;

  typedef struct packed {
    logic [2:0]  char_length;
    logic        is_replacement;
    logic [31:0] running_count;
    logic        text_ended;
    logic        last_of_run;
  } char_item_t;

  // Results produced by one accepted byte (zero, one or two)
  typedef struct packed {
    logic       first_valid;
    logic       second_valid;
    char_item_t first;
    char_item_t second;
  } char_pair_t;

  // Total length of a sequence opened by a valid lead byte
  function automatic logic [2:0] seq_len(input logic [7:0] lead);
    if (lead >= LEAD_4_MIN) begin
      return 3'd4;
    end else if (lead >= LEAD_3_MIN) begin
      return 3'd3;
    end
    return 3'd2;
  endfunction

  // Saturating increment of the running counter
  function automatic logic [COUNT_WIDTH-1:0] count_inc(input logic [COUNT_WIDTH-1:0] c);
    return (c == COUNT_MAX) ? c : c + COUNT_WIDTH'(1);
  endfunction

  // Counter value shown in the 32-bit result field, clamped
  function automatic logic [31:0] count_field(input logic [COUNT_WIDTH-1:0] c);
    logic [63:0] wide;
    wide = 64'(c);
    return (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
  endfunction

endpackage

FILE: src/utf8_seg_core.sv
// ----------------------------------------------------------------------------
// utf8_seg_core
// Sequence state and decode: holds the open sequence and the running count,
// and turns each accepted byte into up to two finished characters.
// ----------------------------------------------------------------------------
module utf8_seg_core import utf8_seg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  byte_item_t item,
  output char_pair_t results
);

  logic [7:0]             pending_lead, pending_lead_next;
  logic [1:0]             pending_bytes, pending_bytes_next;
  logic                   first_cont_was_bf, first_cont_was_bf_next;
  logic [COUNT_WIDTH-1:0] char_counter, char_counter_next;

  logic [7:0]             lo, hi;
  logic [2:0]             need, held_plus;
  logic                   pend, in_range, fresh, eot;
  logic                   a_valid, a_repl, b_valid, b_repl;
  logic [2:0]             a_len;
  logic [COUNT_WIDTH-1:0] count1, count2;

  assign eot       = item.end_of_text;
  assign pend      = (pending_bytes != 2'd0);
  assign need      = seq_len(pending_lead);
  assign held_plus = {1'b0, pending_bytes} + 3'd1;
  assign count1    = count_inc(char_counter);
  assign count2    = count_inc(count1);

  // Allowed window for the next continuation byte
  always_comb begin
    lo = CONT_MIN;
    hi = CONT_MAX;
    if (pending_bytes == 2'd1) begin
      unique case (pending_lead)
        LEAD_E0: lo = E0_CONT_MIN;
        LEAD_ED: hi = ED_CONT_MAX;
        LEAD_F0: lo = F0_CONT_MIN;
        LEAD_F4: hi = F4_CONT_MAX;
        default: ;
      endcase
    end
  end

  assign in_range = (item.data_byte >= lo) && (item.data_byte <= hi);

  // Decode: closing of the open sequence (a), then fresh handling (b)
  always_comb begin
    pending_lead_next      = pending_lead;
    pending_bytes_next     = pending_bytes;
    first_cont_was_bf_next = first_cont_was_bf;
    a_valid = 1'b0;
    a_len   = 3'd0;
    a_repl  = 1'b0;
    b_valid = 1'b0;
    b_repl  = 1'b0;
    fresh   = 1'b1;

    if (pend) begin
      if (in_range) begin
        fresh = 1'b0;
        if (pending_bytes == 2'd1) begin
          first_cont_was_bf_next = (item.data_byte == REPL_MID);
        end
        pending_bytes_next = held_plus[1:0];
        if (held_plus >= need) begin
          // sequence complete; EF BF BD counts as a replacement
          a_valid = 1'b1;
          a_len   = need;
          a_repl  = (pending_lead == REPL_LEAD) && first_cont_was_bf &&
                    (item.data_byte == REPL_LAST);
          pending_lead_next      = 8'd0;
          pending_bytes_next     = 2'd0;
          first_cont_was_bf_next = 1'b0;
        end else if (eot) begin
          // truncated at end of text
          a_valid = 1'b1;
          a_len   = held_plus;
          a_repl  = 1'b1;
          pending_lead_next      = 8'd0;
          pending_bytes_next     = 2'd0;
          first_cont_was_bf_next = 1'b0;
        end
      end else begin
        // breaking byte closes the open subpart
        a_valid = 1'b1;
        a_len   = {1'b0, pending_bytes};
        a_repl  = 1'b1;
        pending_lead_next      = 8'd0;
        pending_bytes_next     = 2'd0;
        first_cont_was_bf_next = 1'b0;
      end
    end

    if (fresh) begin
      if (!item.data_byte[7]) begin
        b_valid = 1'b1;
      end else if ((item.data_byte >= LEAD_MIN) && (item.data_byte <= LEAD_MAX)) begin
        pending_lead_next      = item.data_byte;
        pending_bytes_next     = 2'd1;
        first_cont_was_bf_next = 1'b0;
        if (eot) begin
          b_valid = 1'b1;
          b_repl  = 1'b1;
        end
      end else begin
        // stray continuation or never-valid byte
        b_valid = 1'b1;
        b_repl  = 1'b1;
      end
    end

    // end of text clears everything, counter included
    if (eot) begin
      pending_lead_next      = 8'd0;
      pending_bytes_next     = 2'd0;
      first_cont_was_bf_next = 1'b0;
      char_counter_next      = '0;
    end else if (a_valid && b_valid) begin
      char_counter_next = count2;
    end else if (a_valid || b_valid) begin
      char_counter_next = count1;
    end else begin
      char_counter_next = char_counter;
    end
  end

  // Pack results in order
  always_comb begin
    results = '0;
    results.first_valid  = a_valid || b_valid;
    results.second_valid = a_valid && b_valid;

    results.first.char_length    = a_valid ? a_len : 3'd1;
    results.first.is_replacement = a_valid ? a_repl : b_repl;
    results.first.running_count  = count_field(count1);
    results.first.last_of_run    = !(a_valid && b_valid);
    results.first.text_ended     = eot && !(a_valid && b_valid);

    results.second.char_length    = 3'd1;
    results.second.is_replacement = b_repl;
    results.second.running_count  = count_field(count2);
    results.second.last_of_run    = 1'b1;
    results.second.text_ended     = eot;
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pending_lead      <= 8'd0;
      pending_bytes     <= 2'd0;
      first_cont_was_bf <= 1'b0;
      char_counter      <= '0;
    end else if (take) begin
      pending_lead      <= pending_lead_next;
      pending_bytes     <= pending_bytes_next;
      first_cont_was_bf <= first_cont_was_bf_next;
      char_counter      <= char_counter_next;
    end
  end

endmodule

FILE: src/utf8_seg_outbuf.sv
// ----------------------------------------------------------------------------
// utf8_seg_outbuf
// Result register plus one hold register for the second result of a byte.
// ----------------------------------------------------------------------------
module utf8_seg_outbuf import utf8_seg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       take,
  input  char_pair_t results,
  output logic       can_take,
  output logic       char_valid,
  input  logic       char_ready,
  output char_item_t char_item
);

  logic       hold_valid;
  char_item_t hold_item;
  logic       out_free;

  assign out_free = !char_valid || char_ready;
  assign can_take = !hold_valid && out_free;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
      hold_valid <= 1'b0;
    end else if (hold_valid) begin
      if (out_free) begin
        char_valid <= 1'b1;
        hold_valid <= 1'b0;
      end
    end else if (take) begin
      char_valid <= results.first_valid;
      hold_valid <= results.second_valid;
    end else if (out_free) begin
      char_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (hold_valid) begin
      if (out_free) begin
        char_item <= hold_item;
      end
    end else if (take) begin
      char_item <= results.first;
      hold_item <= results.second;
    end
  end

endmodule

FILE: src/utf8_lossy_char_segmenter_unit.sv
// ----------------------------------------------------------------------------
// utf8_lossy_char_segmenter_unit
// The first character of a byte appears in the cycle after the byte is taken.
// Throughput: 1 byte per cycle while results are not stalled; a byte that ends
// two characters blocks input until the second leaves the hold register.
// Reset clears the open sequence, the running count and both result slots.
// ----------------------------------------------------------------------------
module utf8_lossy_char_segmenter_unit import utf8_seg_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  byte_item_t byte_item,
  output logic       char_valid,
  input  logic       char_ready,
  output char_item_t char_item
);

  logic       take;
  char_pair_t results;

  assign take = byte_valid && byte_ready;

  utf8_seg_core u_core (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .item    (byte_item),
    .results (results)
  );

  utf8_seg_outbuf u_outbuf (
    .clk        (clk),
    .rst        (rst),
    .take       (take),
    .results    (results),
    .can_take   (byte_ready),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item)
  );

endmodule

FILE: tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the UTF-8 lossy character segmenter. A queue of
// request bytes (a short directed set, then mostly well-formed characters with
// truncations, noise and random end-of-text marks) feeds a valid/ready driver.
// A monitor predicts each accepted byte's characters and checks every result,
// field by field and in order, while both sides stall at random.
// ----------------------------------------------------------------------------
module tb_top import utf8_seg_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES = 1100;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_ready;
  byte_item_t byte_item = '0;
  logic       char_valid;
  logic       char_ready = 1'b0;
  char_item_t char_item;

  utf8_lossy_char_segmenter_unit uut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .char_valid (char_valid),
    .char_ready (char_ready),
    .char_item  (char_item)
  );

  // Request bytes waiting to be sent, characters waiting to be seen
  byte_item_t pending_bytes [$];
  char_item_t expected_chars [$];

  // Predictor state
  logic [7:0]             open_lead = '0;
  int                     open_cnt  = 0;
  logic                   open_bf   = 1'b0;
  logic [COUNT_WIDTH-1:0] char_total = '0;

  // Handshake history and idling
  logic byte_fire = 1'b0;
  logic char_fire = 1'b0;
  int   send_gap = 0;
  int   ready_wait = 0;
  int   stall_draw = 0;
  int   cycle_count = 0;

  // Statistics and errors
  int         mismatches = 0;
  int         bytes_taken = 0;
  int         chars_checked = 0;
  int         repl_checked = 0;
  int         texts_seen = 0;
  char_item_t want_char;

  initial begin
    forever #2 clk = ~clk;
  end

  // Bounds of the first continuation byte after a given lead
  function automatic void first_cont_bounds(input logic [7:0] lead,
                                            output logic [7:0] lo,
                                            output logic [7:0] hi);
    lo = CONT_MIN;
    hi = CONT_MAX;
    case (lead)
      LEAD_E0: lo = E0_CONT_MIN;
      LEAD_ED: hi = ED_CONT_MAX;
      LEAD_F0: lo = F0_CONT_MIN;
      LEAD_F4: hi = F4_CONT_MAX;
      default: ;
    endcase
  endfunction

  function automatic logic [2:0] seq_bytes(input logic [7:0] lead);
    if (lead >= LEAD_4_MIN) begin
      return 3'd4;
    end
    return (lead >= LEAD_3_MIN) ? 3'd3 : 3'd2;
  endfunction

  function automatic void clear_open();
    open_lead = '0;
    open_cnt  = 0;
    open_bf   = 1'b0;
  endfunction

  // Count one finished character and build its result
  function automatic char_item_t close_char(input logic [2:0] len, input logic repl);
    char_item_t c;
    logic [63:0] wide;
    if (char_total != COUNT_MAX) begin
      char_total = char_total + 1'b1;
    end
    wide = 64'(char_total);
    c = '0;
    c.char_length    = len;
    c.is_replacement = repl;
    c.running_count  = (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
    return c;
  endfunction

  // Predict the characters finished by one accepted byte
  function automatic void segment_byte(input byte_item_t it);
    char_item_t res [2];
    int         k;
    int         held;
    logic [7:0] b;
    logic [7:0] lo;
    logic [7:0] hi;
    logic [2:0] need;
    logic       fresh;
    b = it.data_byte;
    k = 0;
    fresh = 1'b1;
    if (open_cnt != 0) begin
      need = seq_bytes(open_lead);
      lo = CONT_MIN;
      hi = CONT_MAX;
      if (open_cnt == 1) begin
        first_cont_bounds(open_lead, lo, hi);
      end
      if (b >= lo && b <= hi) begin
        fresh = 1'b0;
        if (open_cnt == 1) begin
          open_bf = (b == REPL_MID);
        end
        held = open_cnt + 1;
        if (held >= need) begin
          res[k] = close_char(need, open_lead == REPL_LEAD && open_bf && b == REPL_LAST);
          k++;
          clear_open();
        end else if (it.end_of_text) begin
          // truncated at end of text
          res[k] = close_char(3'(held), 1'b1);
          k++;
          clear_open();
        end else begin
          open_cnt = held;
        end
      end else begin
        // breaking byte closes the open sequence, then starts over
        res[k] = close_char(3'(open_cnt), 1'b1);
        k++;
        clear_open();
      end
    end
    if (fresh) begin
      if (b < CONT_MIN) begin
        res[k] = close_char(3'd1, 1'b0);
        k++;
      end else if (b >= LEAD_MIN && b <= LEAD_MAX) begin
        if (it.end_of_text) begin
          res[k] = close_char(3'd1, 1'b1);
          k++;
        end else begin
          open_lead = b;
          open_cnt  = 1;
          open_bf   = 1'b0;
        end
      end else begin
        // stray continuation or forbidden byte
        res[k] = close_char(3'd1, 1'b1);
        k++;
      end
    end
    if (k > 0) begin
      res[k-1].last_of_run = 1'b1;
      res[k-1].text_ended  = it.end_of_text;
    end
    for (int i = 0; i < k; i++) begin
      expected_chars = {expected_chars, res[i]};
    end
    if (it.end_of_text) begin
      clear_open();
      char_total = '0;
      texts_seen++;
    end
  endfunction

  function automatic void compare_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  function automatic void push_byte(input logic [7:0] b, input logic eot);
    byte_item_t it;
    it.data_byte   = b;
    it.end_of_text = eot;
    pending_bytes = {pending_bytes, it};
  endfunction

  // One random character: mostly valid, some truncated, some noise
  function automatic int add_random_char();
    logic [7:0] seq [4];
    logic [7:0] lo;
    logic [7:0] hi;
    int         kind;
    int         n;
    int         cut;
    kind = $urandom_range(0, 99);
    n = 1;
    if (kind < 25) begin
      seq[0] = 8'($urandom_range(0, 8'h7F));
    end else if (kind < 45) begin
      seq[0] = 8'($urandom_range(LEAD_MIN, 8'hDF));
      n = 2;
    end else if (kind < 65) begin
      seq[0] = 8'($urandom_range(LEAD_3_MIN, 8'hEF));
      n = 3;
    end else if (kind < 80) begin
      seq[0] = 8'($urandom_range(LEAD_4_MIN, LEAD_MAX));
      n = 4;
    end else if (kind < 86) begin
      seq[0] = REPL_LEAD;
      seq[1] = REPL_MID;
      seq[2] = REPL_LAST;
      n = 3;
    end else begin
      seq[0] = 8'($urandom_range(0, 255));
    end
    if (n > 1 && kind < 80) begin
      first_cont_bounds(seq[0], lo, hi);
      seq[1] = 8'($urandom_range(lo, hi));
      for (int i = 2; i < n; i++) begin
        seq[i] = 8'($urandom_range(CONT_MIN, CONT_MAX));
      end
    end
    cut = n;
    if (n > 1 && $urandom_range(0, 9) == 0) begin
      cut = $urandom_range(1, n - 1);
    end
    for (int i = 0; i < cut; i++) begin
      push_byte(seq[i], (i == cut - 1) && ($urandom_range(0, 24) == 0));
    end
    return cut;
  endfunction

  // Directed bytes, {end_of_text, data_byte}
  logic [8:0] directed_bytes [25] = '{
    9'h000, 9'h07F, 9'h080, 9'h0C0, 9'h0FF,   // extremes, stray and forbidden
    9'h0C2, 9'h080,                           // shortest 2-byte
    9'h0ED, 9'h0A0,                           // ED bound broken
    9'h0E0, 9'h0A0, 9'h0BF,                   // E0 at lower bound
    9'h0EF, 9'h0BF, 9'h0BD,                   // literal replacement char
    9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,           // top code point
    9'h0F0, 9'h08F,                           // F0 bound broken
    9'h0C3, 9'h1C3,                           // lead breaks lead, lead at end
    9'h0E2, 9'h182                            // truncated at end of text
  };

  // Stimulus, reset and end of run
  initial begin
    int queued;
    foreach (directed_bytes[i]) begin
      push_byte(directed_bytes[i][7:0], directed_bytes[i][8]);
    end
    queued = 0;
    while (queued < RANDOM_BYTES) begin
      queued += add_random_char();
    end
    repeat (2) @(negedge clk);
    rst <= 1'b0;
    while (pending_bytes.size() != 0 || byte_valid) begin
      @(posedge clk);
    end
    while (expected_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d bytes over %0d ended texts; checked %0d characters, %0d replacements.",
             bytes_taken, texts_seen, chars_checked, repl_checked);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Request driver: holds each byte until taken, then may idle at random before the next
  always @(negedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (!byte_valid || byte_fire) begin
      if (send_gap > 0) begin
        byte_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_bytes.size() > 0) begin
        byte_item  <= pending_bytes.pop_front();
        byte_valid <= 1'b1;
        send_gap   <= (((cycle_count / 700) % 4) == 3) ? 0 : $urandom_range(0, 3);
      end else begin
        byte_valid <= 1'b0;
      end
    end
  end

  // Result receiver: after each result, may stall at random before taking the next
  always @(negedge clk) begin
    if (rst) begin
      char_ready <= 1'b0;
      ready_wait <= 0;
    end else if (char_fire) begin
      if (((cycle_count / 512) % 4) == 3) begin
        ready_wait <= 0;
        char_ready <= 1'b1;
      end else begin
        stall_draw = $urandom_range(0, 3);
        ready_wait <= stall_draw;
        char_ready <= (stall_draw == 0);
      end
    end else if (ready_wait > 0) begin
      ready_wait <= ready_wait - 1;
      char_ready <= (ready_wait == 1);
    end else begin
      char_ready <= 1'b1;
    end
  end

  // Monitor: predict on accepted bytes, check accepted results
  always @(posedge clk) begin
    if (rst) begin
      byte_fire <= 1'b0;
      char_fire <= 1'b0;
    end else begin
      byte_fire <= byte_valid && byte_ready;
      char_fire <= char_valid && char_ready;
      if (byte_valid && byte_ready) begin
        bytes_taken++;
        segment_byte(byte_item);
      end
      if (char_valid && char_ready) begin
        if (expected_chars.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, actual %p", $time, char_item);
        end else begin
          want_char = expected_chars.pop_front();
          chars_checked++;
          if (want_char.is_replacement) begin
            repl_checked++;
          end
          compare_field("char_length", 32'(want_char.char_length), 32'(char_item.char_length));
          compare_field("is_replacement", 32'(want_char.is_replacement),
                        32'(char_item.is_replacement));
          compare_field("running_count", want_char.running_count, char_item.running_count);
          compare_field("text_ended", 32'(want_char.text_ended), 32'(char_item.text_ended));
          compare_field("last_of_run", 32'(want_char.last_of_run), 32'(char_item.last_of_run));
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_chars.size());
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
